@@ rtl/gmtz_pkg.sv @@
// Shared constants and types for the grid minimum trailing zero path block.
`default_nettype none

package gmtz_pkg;

  localparam int MAX_SIDE   = 64;
  localparam int SIDE_W     = 7;
  localparam int COL_W      = $clog2(MAX_SIDE);
  localparam int VALUE_W    = 32;
  localparam int TOTAL_W    = 12;
  localparam int C2_W       = 5;
  localparam int C5_W       = 4;
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Exact division by five: v * INV5 mod 2^32, divisible when the product is <= DIV5_LIMIT.
  localparam logic [VALUE_W-1:0] INV5       = 32'hCCCC_CCCD;
  localparam logic [VALUE_W-1:0] DIV5_LIMIT = 32'h3333_3333;

  typedef struct packed {
    logic [C2_W-1:0] c2;
    logic [C5_W-1:0] c5;
    logic            zero;
  } factor_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] twos;
    logic [TOTAL_W-1:0] fives;
  } row_t;

endpackage

`default_nettype wire

@@ rtl/gmtz_if.sv @@
// Valid/ready channel interfaces for cell words and result words.
`default_nettype none

interface gmtz_cell_if;
  import gmtz_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface gmtz_result_if;
  import gmtz_pkg::*;
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] min_trailing_zeros;

  modport source (output valid, output min_trailing_zeros, input ready);
  modport sink   (input valid, input min_trailing_zeros, output ready);
endinterface

`default_nettype wire

@@ rtl/gmtz_front.sv @@
// Front end: accepts a cell word and counts its factors of two and five.
`default_nettype none

module gmtz_front (
  input  wire logic              clk,
  input  wire logic              rst,
  gmtz_cell_if.sink              cells,
  output gmtz_pkg::factor_t      push_data,
  output logic                   push,
  input  wire logic              full
);
  import gmtz_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_TWOS  = 4'b0010,
    S_FIVES = 4'b0100,
    S_PUSH  = 4'b1000
  } front_state_t;

  front_state_t       state;
  logic [VALUE_W-1:0] v;
  logic [C2_W-1:0]    c2;
  logic [C5_W-1:0]    c5;
  logic               zero;
  logic [VALUE_W-1:0] prod;
  logic [VALUE_W-1:0] v_shift;
  logic [C2_W-1:0]    tz;

  assign cells.ready = (state == S_IDLE);
  assign push        = (state == S_PUSH) && !full;
  assign push_data   = '{c2: c2, c5: c5, zero: zero};
  assign prod        = v * INV5;

  // strip up to four trailing zeros per cycle
  always_comb begin
    case (v[3:0])
      4'b0000: begin
        tz      = C2_W'(4);
        v_shift = v >> 4;
      end
      4'b1000: begin
        tz      = C2_W'(3);
        v_shift = v >> 3;
      end
      4'b0100, 4'b1100: begin
        tz      = C2_W'(2);
        v_shift = v >> 2;
      end
      4'b0010, 4'b0110, 4'b1010, 4'b1110: begin
        tz      = C2_W'(1);
        v_shift = v >> 1;
      end
      default: begin
        tz      = '0;
        v_shift = v;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (cells.valid) begin
            if (cells.cell_value == '0) begin
              state <= S_PUSH;
            end else begin
              state <= S_TWOS;
            end
          end
        end
        S_TWOS: begin
          if (v[0]) begin
            state <= S_FIVES;
          end
        end
        S_FIVES: begin
          if (prod > DIV5_LIMIT) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        v <= cells.cell_value;
        if (cells.cell_value == '0) begin
          c2   <= C2_W'(1);
          c5   <= C5_W'(1);
          zero <= 1'b1;
        end else begin
          c2   <= '0;
          c5   <= '0;
          zero <= 1'b0;
        end
      end
      S_TWOS: begin
        v  <= v_shift;
        c2 <= c2 + tz;
      end
      S_FIVES: begin
        if (prod <= DIV5_LIMIT) begin
          v  <= prod;
          c5 <= c5 + C5_W'(1);
        end
      end
      default: begin
        v <= v;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/gmtz_fifo.sv @@
// Short queue of factor counts between front and back.
`default_nettype none

module gmtz_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  gmtz_pkg::factor_t      push_data,
  output logic                   full,
  input  wire logic              pop,
  output gmtz_pkg::factor_t      pop_data,
  output logic                   empty
);
  import gmtz_pkg::*;

  factor_t          slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full     = (count == (PTR_W+1)'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/gmtz_back.sv @@
// Back end: path-minimum update over the row memory and the result register.
`default_nettype none

module gmtz_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [gmtz_pkg::SIDE_W-1:0] side,
  input  wire logic                      restart,
  input  wire logic                      empty,
  input  gmtz_pkg::factor_t              pop_data,
  output logic                           pop,
  gmtz_result_if.source                  result
);
  import gmtz_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_CALC = 2'b10
  } back_state_t;

  back_state_t        state;
  factor_t            ent;
  row_t               row_mem [MAX_SIDE];
  row_t               above;
  row_t               n_row;
  logic [COL_W-1:0]   row_idx;
  logic [COL_W-1:0]   col_idx;
  logic [TOTAL_W-1:0] twos_left;
  logic [TOTAL_W-1:0] fives_left;
  logic               zero_seen;
  logic               out_valid;
  logic [TOTAL_W-1:0] out_data;

  logic               first_row;
  logic               first_col;
  logic               last_col;
  logic               last_row;
  logic               last_cell;
  logic               go;
  logic [TOTAL_W-1:0] base2;
  logic [TOTAL_W-1:0] base5;
  logic [TOTAL_W:0]   sum2;
  logic [TOTAL_W:0]   sum5;
  logic [TOTAL_W-1:0] ans;

  assign result.valid              = out_valid;
  assign result.min_trailing_zeros = out_data;

  assign pop       = (state == B_IDLE) && !empty;
  assign first_row = (row_idx == '0);
  assign first_col = (col_idx == '0);
  assign last_col  = (SIDE_W'(col_idx) + SIDE_W'(1)) >= side;
  assign last_row  = (SIDE_W'(row_idx) + SIDE_W'(1)) >= side;
  assign last_cell = last_col && last_row;
  assign go        = (state == B_CALC) && (!last_cell || !out_valid || result.ready);

  always_comb begin
    if (first_row && first_col) begin
      base2 = '0;
      base5 = '0;
    end else if (first_row) begin
      base2 = twos_left;
      base5 = fives_left;
    end else if (first_col) begin
      base2 = above.twos;
      base5 = above.fives;
    end else begin
      base2 = (above.twos < twos_left) ? above.twos : twos_left;
      base5 = (above.fives < fives_left) ? above.fives : fives_left;
    end
    sum2 = {1'b0, base2} + (TOTAL_W+1)'(ent.c2);
    sum5 = {1'b0, base5} + (TOTAL_W+1)'(ent.c5);
    n_row.twos  = sum2[TOTAL_W] ? TOTAL_MAX : sum2[TOTAL_W-1:0];
    n_row.fives = sum5[TOTAL_W] ? TOTAL_MAX : sum5[TOTAL_W-1:0];
    ans = (n_row.twos < n_row.fives) ? n_row.twos : n_row.fives;
    // any zero cell gives a path product of zero, i.e. one trailing zero counted
    if ((zero_seen || ent.zero) && ans > TOTAL_W'(1)) begin
      ans = TOTAL_W'(1);
    end
  end

  // row memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (go) begin
      row_mem[col_idx] <= n_row;
    end
    if (pop) begin
      above <= row_mem[col_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent <= pop_data;
    end
    if (go && last_cell) begin
      out_data <= ans;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      row_idx    <= '0;
      col_idx    <= '0;
      twos_left  <= '0;
      fives_left <= '0;
      zero_seen  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (go && last_cell && !restart) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (restart) begin
        row_idx    <= '0;
        col_idx    <= '0;
        twos_left  <= '0;
        fives_left <= '0;
        zero_seen  <= 1'b0;
      end else begin
        case (state)
          B_IDLE: begin
            if (!empty) begin
              state <= B_CALC;
            end
          end
          B_CALC: begin
            if (go) begin
              state      <= B_IDLE;
              // left minima and zero flag start over with the next grid
              twos_left  <= last_cell ? '0 : n_row.twos;
              fives_left <= last_cell ? '0 : n_row.fives;
              zero_seen  <= !last_cell && (zero_seen || ent.zero);
              if (last_col) begin
                col_idx <= '0;
                if (last_row) begin
                  row_idx <= '0;
                end else begin
                  row_idx <= row_idx + COL_W'(1);
                end
              end else begin
                col_idx <= col_idx + COL_W'(1);
              end
            end
          end
          default: state <= B_IDLE;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/grid_min_trailing_zero_path.sv @@
// Top level: least trailing zeros over monotone paths of a square grid.
//
//   channel     dir  word                       handshake
//   cells       in   cell_value[31:0]           valid/ready
//   result      out  min_trailing_zeros[11:0]   valid/ready
//   grid_side   in   grid_side[6:0]             grid_side_we, no wait
//
// A cell holds the front from accept to the queue push: it strips up to four trailing zero
// bits at a time until odd, then does one 32-bit reciprocal multiply per factor of five
// (up to 13) until one fails; a zero cell goes straight to the push. The back pops each
// cell, then updates the row memory. Reset is synchronous; the row memory is not cleared.
// A stalled result only holds the back on the last cell; the front keeps filling the queue.
`default_nettype none

module grid_min_trailing_zero_path (
  input  wire logic                         clk,
  input  wire logic                         rst,
  gmtz_cell_if.sink                         cells,
  gmtz_result_if.source                     result,
  input  wire logic                         grid_side_we,
  input  wire logic [gmtz_pkg::SIDE_W-1:0]  grid_side
);
  import gmtz_pkg::*;

  logic [SIDE_W-1:0] side_reg;
  logic [SIDE_W-1:0] side;
  factor_t           push_data;
  factor_t           pop_data;
  logic              push;
  logic              pop;
  logic              full;
  logic              empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_reg <= SIDE_W'(MAX_SIDE);
    end else if (grid_side_we) begin
      side_reg <= grid_side;
    end
  end

  always_comb begin
    if (side_reg == '0) begin
      side = SIDE_W'(1);
    end else if (side_reg > SIDE_W'(MAX_SIDE)) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = side_reg;
    end
  end

  gmtz_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cells     (cells),
    .push_data (push_data),
    .push      (push),
    .full      (full)
  );

  gmtz_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  gmtz_back u_back (
    .clk      (clk),
    .rst      (rst),
    .side     (side),
    .restart  (grid_side_we),
    .empty    (empty),
    .pop_data (pop_data),
    .pop      (pop),
    .result   (result)
  );

endmodule

`default_nettype wire

@@ rtl/gmtz_checker.sv @@
// Port-level checks for the top level, bound into it.
`default_nettype none

module gmtz_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          cell_valid,
  input wire logic                          cell_ready,
  input wire logic                          res_valid,
  input wire logic                          res_ready,
  input wire logic [gmtz_pkg::TOTAL_W-1:0]  res_data
);

  // a result word waits until taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result word dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_data))
    else $error("result word changed while stalled");

  // the front works on one cell at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cell_valid && cell_ready |=> !cell_ready)
    else $error("cell taken while front busy");

  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> (!res_valid && cell_ready))
    else $error("bad state after reset");

endmodule

bind grid_min_trailing_zero_path gmtz_checker u_gmtz_checker (
  .clk        (clk),
  .rst        (rst),
  .cell_valid (cells.valid),
  .cell_ready (cells.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_data   (result.min_trailing_zeros)
);

`default_nettype wire
